// ----- rtl/qvr_pkg.sv -----
// Package for the quaternion vector rotation core.
// Holds the fixed-point widths, payload types and rounding constants; no dependencies.
package qvr_pkg;

  // Field widths
  localparam int QW = 16;          // quaternion component, Q2.14
  localparam int VW = 24;          // vector component, 8 fraction bits
  localparam int PW = QW + VW;     // q*v product
  localparam int TW = PW + 1;      // sum of three q*v products
  localparam int MW = TW + QW;     // t*q product
  localparam int RW = 60;          // sum of four t*q products plus rounding
  localparam int FRAC_DROP = 28;   // 36 fraction bits down to 8
  localparam int SW = RW - FRAC_DROP;

  // Quaternion component indexes
  localparam int QI_W = 0;
  localparam int QI_X = 1;
  localparam int QI_Y = 2;
  localparam int QI_Z = 3;

  // Vector component indexes
  localparam int VI_X = 0;
  localparam int VI_Y = 1;
  localparam int VI_Z = 2;

  typedef logic signed [QW-1:0] quat_t;
  typedef logic signed [VW-1:0] vec_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [TW-1:0] tsum_t;
  typedef logic signed [MW-1:0] mprod_t;
  typedef logic signed [RW-1:0] acc_t;

  // Half an output LSB at 36 fraction bits
  localparam acc_t RND_HALF = acc_t'(64'sd1 <<< (FRAC_DROP - 1));

  localparam vec_t VEC_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam vec_t VEC_MIN = {1'b1, {(VW-1){1'b0}}};

endpackage

// ----- rtl/qvr_round_sat.sv -----
// Round-half-up and saturate one rotated component to the vector format.
// Depends on qvr_pkg for widths and limits.
module qvr_round_sat
  import qvr_pkg::*;
(
  input  acc_t acc,     // exact sum with rounding half already added
  output vec_t rot,
  output logic clip
);

  logic [SW-1:0] shifted;
  logic          fits;

  // Drop the fraction bits: floor of the division by 2^FRAC_DROP
  assign shifted = acc[RW-1:FRAC_DROP];

  // Fits when every bit above the output sign matches it
  assign fits = (shifted[SW-1:VW-1] == {(SW-VW+1){1'b0}}) ||
                (shifted[SW-1:VW-1] == {(SW-VW+1){1'b1}});

  // Clamp toward the sign of the wide value
  always_comb begin
    if (fits) begin
      rot = vec_t'(shifted[VW-1:0]);
    end else if (shifted[SW-1]) begin
      rot = VEC_MIN;
    end else begin
      rot = VEC_MAX;
    end
  end

  assign clip = !fits;

endmodule

// ----- rtl/quaternion_vector_rotation_core.sv -----
// Quaternion vector rotation core: rotates v by q as vec(q * (0,v) * conj(q)).
// Throughput: one item per cycle, unless out_ready low stalls a full pipeline.
// Five register stages: q*v products, t sums, t*q products, r sums, round/saturate.
// Each stage holds its own valid bit and advances when empty or its successor advances.
// Reset (rst_n, synchronous) clears the valid bits only; payload registers are not reset.
// Depends on qvr_pkg and qvr_round_sat.
module quaternion_vector_rotation_core
  import qvr_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  quat_t in_quat_w,
  input  quat_t in_quat_x,
  input  quat_t in_quat_y,
  input  quat_t in_quat_z,
  input  vec_t  in_vec_x,
  input  vec_t  in_vec_y,
  input  vec_t  in_vec_z,
  output logic  out_valid,
  input  logic  out_ready,
  output vec_t  out_rot_x,
  output vec_t  out_rot_y,
  output vec_t  out_rot_z,
  output logic  out_clipped
);

  // Stage valid bits and advance enables
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_r || out_ready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_ready  = en1;
  assign out_valid = v5_r;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  // Stage 1: all twelve q*v products
  quat_t q_in [4];
  vec_t  v_in [3];
  prod_t p1_r [4][3];
  quat_t q1_r [4];

  assign q_in[QI_W] = in_quat_w;
  assign q_in[QI_X] = in_quat_x;
  assign q_in[QI_Y] = in_quat_y;
  assign q_in[QI_Z] = in_quat_z;
  assign v_in[VI_X] = in_vec_x;
  assign v_in[VI_Y] = in_vec_y;
  assign v_in[VI_Z] = in_vec_z;

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int i = 0; i < 4; i++) begin
        q1_r[i] <= q_in[i];
        for (int j = 0; j < 3; j++) begin
          p1_r[i][j] <= prod_t'(q_in[i]) * prod_t'(v_in[j]);
        end
      end
    end
  end

  // Stage 2: t = q * (0,v)
  tsum_t t2_nxt [4];
  tsum_t t2_r   [4];
  quat_t q2_r   [4];

  always_comb begin
    t2_nxt[0] = -tsum_t'(p1_r[QI_X][VI_X]) - tsum_t'(p1_r[QI_Y][VI_Y])
                - tsum_t'(p1_r[QI_Z][VI_Z]);
    t2_nxt[1] =  tsum_t'(p1_r[QI_W][VI_X]) + tsum_t'(p1_r[QI_Y][VI_Z])
                - tsum_t'(p1_r[QI_Z][VI_Y]);
    t2_nxt[2] =  tsum_t'(p1_r[QI_W][VI_Y]) - tsum_t'(p1_r[QI_X][VI_Z])
                + tsum_t'(p1_r[QI_Z][VI_X]);
    t2_nxt[3] =  tsum_t'(p1_r[QI_W][VI_Z]) + tsum_t'(p1_r[QI_X][VI_Y])
                - tsum_t'(p1_r[QI_Y][VI_X]);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      for (int i = 0; i < 4; i++) begin
        t2_r[i] <= t2_nxt[i];
        q2_r[i] <= q1_r[i];
      end
    end
  end

  // Stage 3: all sixteen t*q products
  mprod_t m3_r [4][4];

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          m3_r[i][j] <= mprod_t'(t2_r[i]) * mprod_t'(q2_r[j]);
        end
      end
    end
  end

  // Stage 4: vector part of t * conj(q), plus the rounding half
  acc_t r4_nxt [3];
  acc_t r4_r   [3];

  always_comb begin
    r4_nxt[0] = RND_HALF - acc_t'(m3_r[0][QI_X]) + acc_t'(m3_r[1][QI_W])
                - acc_t'(m3_r[2][QI_Z]) + acc_t'(m3_r[3][QI_Y]);
    r4_nxt[1] = RND_HALF - acc_t'(m3_r[0][QI_Y]) + acc_t'(m3_r[1][QI_Z])
                + acc_t'(m3_r[2][QI_W]) - acc_t'(m3_r[3][QI_X]);
    r4_nxt[2] = RND_HALF - acc_t'(m3_r[0][QI_Z]) - acc_t'(m3_r[1][QI_Y])
                + acc_t'(m3_r[2][QI_X]) + acc_t'(m3_r[3][QI_W]);
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      for (int i = 0; i < 3; i++) begin
        r4_r[i] <= r4_nxt[i];
      end
    end
  end

  // Stage 5: round, saturate and hold the result
  vec_t rot_nxt  [3];
  logic clip_nxt [3];
  vec_t rot_r    [3];
  logic clip_r;

  for (genvar g = 0; g < 3; g++) begin : g_rsat
    qvr_round_sat u_rsat (
      .acc  (r4_r[g]),
      .rot  (rot_nxt[g]),
      .clip (clip_nxt[g])
    );
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      for (int i = 0; i < 3; i++) begin
        rot_r[i] <= rot_nxt[i];
      end
      clip_r <= clip_nxt[0] | clip_nxt[1] | clip_nxt[2];
    end
  end

  assign out_rot_x   = rot_r[VI_X];
  assign out_rot_y   = rot_r[VI_Y];
  assign out_rot_z   = rot_r[VI_Z];
  assign out_clipped = clip_r;

  // A stalled output must freeze a full stage behind it
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && !out_ready && v4_r) |=> (v4_r && v5_r))
    else $error("stage 4 item lost while output stalled");

  // Clipping shows only with an extreme component
  a_clip_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clipped) |->
      (out_rot_x == VEC_MAX || out_rot_x == VEC_MIN ||
       out_rot_y == VEC_MAX || out_rot_y == VEC_MIN ||
       out_rot_z == VEC_MAX || out_rot_z == VEC_MIN))
    else $error("clipped set without a saturated component");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !v1_r && !v4_r))
    else $error("valid bit survived reset");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Testbench for quaternion_vector_rotation_core: drives quaternion/vector pairs and checks
// each rotated vector against an exact integer predictor kept in a small scoreboard class.
// Depends on qvr_pkg and the core RTL.

module tb;
  import qvr_pkg::*;

  localparam int RANDOM_ITEMS = 1000;
  localparam int QUIET_ITEMS  = 150;     // tail of the run with no idling on either side
  localparam int HOLD_AT      = 150;     // transfers seen before the long receiver hold-off
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 12;      // idle time after the last expected result has arrived
  localparam int TIMEOUT_NS   = 500000;

  typedef struct {
    quat_t w;
    quat_t x;
    quat_t y;
    quat_t z;
    vec_t  vx;
    vec_t  vy;
    vec_t  vz;
  } rot_req_t;

  typedef struct {
    vec_t x;
    vec_t y;
    vec_t z;
    logic clipped;
  } rot_res_t;

  // Predicts rotated vectors and matches them in order against the output stream
  class rotation_scoreboard;
    rot_res_t pending_rotations[$];
    int rotations_checked = 0;
    int saturated_results = 0;
    int mismatches = 0;

    // vec(q * (0,v) * conj(q)) in exact 64-bit integers, then round half up and clamp
    function rot_res_t rotate_vector(rot_req_t req);
      longint w, x, y, z, px, py, pz;
      longint t0, t1, t2, t3;
      longint r [3];
      longint rounded;
      vec_t comp [3];
      rot_res_t res;
      w = req.w;
      x = req.x;
      y = req.y;
      z = req.z;
      px = req.vx;
      py = req.vy;
      pz = req.vz;
      t0 = -x * px - y * py - z * pz;
      t1 =  w * px + y * pz - z * py;
      t2 =  w * py - x * pz + z * px;
      t3 =  w * pz + x * py - y * px;
      r[0] = -t0 * x + t1 * w - t2 * z + t3 * y;
      r[1] = -t0 * y + t1 * z + t2 * w - t3 * x;
      r[2] = -t0 * z - t1 * y + t2 * x + t3 * w;
      res.clipped = 1'b0;
      for (int i = 0; i < 3; i++) begin
        rounded = (r[i] + (64'sd1 <<< (FRAC_DROP - 1))) >>> FRAC_DROP;
        if (rounded > longint'(VEC_MAX)) begin
          comp[i] = VEC_MAX;
          res.clipped = 1'b1;
        end else if (rounded < longint'(VEC_MIN)) begin
          comp[i] = VEC_MIN;
          res.clipped = 1'b1;
        end else begin
          comp[i] = vec_t'(rounded);
        end
      end
      res.x = comp[0];
      res.y = comp[1];
      res.z = comp[2];
      return res;
    endfunction

    function void note_vector(rot_req_t req);
      pending_rotations.push_back(rotate_vector(req));
    endfunction

    function int pending();
      return pending_rotations.size();
    endfunction

    function void compare_field(string name, vec_t want_v, vec_t got_v);
      if (got_v !== want_v) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
        mismatches++;
      end
    endfunction

    function void check_rotation(rot_res_t got);
      rot_res_t want;
      if (pending_rotations.size() == 0) begin
        $display("%0t: result transfer with nothing expected (x %0d y %0d z %0d)",
                 $time, got.x, got.y, got.z);
        mismatches++;
        return;
      end
      want = pending_rotations.pop_front();
      rotations_checked++;
      if (want.clipped) saturated_results++;
      compare_field("rot_x", want.x, got.x);
      compare_field("rot_y", want.y, got.y);
      compare_field("rot_z", want.z, got.z);
      compare_field("clipped", vec_t'(want.clipped), vec_t'(got.clipped));
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  quat_t in_quat_w = '0;
  quat_t in_quat_x = '0;
  quat_t in_quat_y = '0;
  quat_t in_quat_z = '0;
  vec_t  in_vec_x = '0;
  vec_t  in_vec_y = '0;
  vec_t  in_vec_z = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  vec_t  out_rot_x;
  vec_t  out_rot_y;
  vec_t  out_rot_z;
  logic  out_clipped;

  rotation_scoreboard sb = new;
  int items_sent = 0;
  int input_stall_cycles = 0;
  bit quiet = 1'b0;

  quaternion_vector_rotation_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_quat_w  (in_quat_w),
    .in_quat_x  (in_quat_x),
    .in_quat_y  (in_quat_y),
    .in_quat_z  (in_quat_z),
    .in_vec_x   (in_vec_x),
    .in_vec_y   (in_vec_y),
    .in_vec_z   (in_vec_z),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_rot_x  (out_rot_x),
    .out_rot_y  (out_rot_y),
    .out_rot_z  (out_rot_z),
    .out_clipped(out_clipped)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Offer one item, hold it until the transfer, then maybe idle for a burst
  task automatic send_request(int w, int x, int y, int z, int vx, int vy, int vz);
    rot_req_t req;
    req.w = quat_t'(w);
    req.x = quat_t'(x);
    req.y = quat_t'(y);
    req.z = quat_t'(z);
    req.vx = vec_t'(vx);
    req.vy = vec_t'(vy);
    req.vz = vec_t'(vz);
    in_valid  <= 1'b1;
    in_quat_w <= req.w;
    in_quat_x <= req.x;
    in_quat_y <= req.y;
    in_quat_z <= req.z;
    in_vec_x  <= req.vx;
    in_vec_y  <= req.vy;
    in_vec_z  <= req.vz;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_vector(req);
    items_sent++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  function automatic int rand_span(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Stimulus: directed corners, then a random mix, then drain and report
  initial begin : stimulus
    int kind;
    int directed_items;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // identity and its negation leave the vector unchanged
    send_request(16384, 0, 0, 0, 256, -512, 1000);
    send_request(-16384, 0, 0, 0, -77, 3, 8388607);
    send_request(16384, 0, 0, 0, 8388607, -8388608, 0);
    // zero quaternion collapses everything
    send_request(0, 0, 0, 0, 8388607, -8388608, 8388607);
    // half turns about each axis, one of them negating the most negative value
    send_request(0, 16384, 0, 0, 1, 2, 3);
    send_request(0, 16384, 0, 0, 5, -8388608, 9);
    send_request(0, 0, 16384, 0, -1000, 2000, -3000);
    send_request(0, 0, 0, 16384, 123456, -654321, 42);
    // quarter turn about z
    send_request(11585, 0, 0, 11585, 256, 0, 0);
    // exact half-LSB results: quaternion scale 1/16 puts vx/16 on the rounding point
    send_request(4096, 0, 0, 0, 8, -8, 24);
    send_request(4096, 0, 0, 0, -24, 7, -9);
    // most negative and most positive quaternions with extreme vectors
    send_request(-32768, -32768, -32768, -32768, 8388607, -8388608, 8388607);
    send_request(32767, 32767, 32767, 32767, -8388608, -8388608, -8388608);
    send_request(32767, 0, 0, 0, 8388607, 8388607, 8388607);
    send_request(32767, 0, 0, 0, -8388608, -8388608, -8388608);
    // saturation on a single component only
    send_request(32767, 0, 0, 0, 1000, 8388607, -5);
    // tiny quaternions round everything to zero or one LSB
    send_request(1, 1, 1, 1, 8388607, 8388607, 8388607);
    send_request(-1, -1, -1, -1, -8388608, 8388607, -1);
    directed_items = items_sent;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= RANDOM_ITEMS - QUIET_ITEMS);
      kind = $urandom_range(0, 19);
      if (kind < 5) begin
        // raw bit patterns everywhere
        send_request(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                     int'($urandom), int'($urandom), int'($urandom));
      end else if (kind < 13) begin
        // quaternion norm up to about 1.41, full-range vector: mixes clipped and clean
        send_request(rand_span(11585), rand_span(11585), rand_span(11585),
                     rand_span(11585), int'($urandom), int'($urandom), int'($urandom));
      end else if (kind < 17) begin
        // near-rotation quaternions on moderate vectors: mostly unclipped
        send_request(rand_span(16384), rand_span(4096), rand_span(4096), rand_span(4096),
                     rand_span(1 << 20), rand_span(1 << 20), rand_span(1 << 20));
      end else begin
        // large quaternions on short vectors exercise the rounding bits
        send_request(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                     rand_span(4096), rand_span(4096), rand_span(4096));
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d vector transfers (%0d directed), %0d rotations checked, %0d saturated.",
             items_sent, directed_items, sb.rotations_checked, sb.saturated_results);
    $display("Input side was held off for %0d cycles; %0d mismatches found.",
             input_stall_cycles, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off to back the pipeline up, none at the end
  initial begin : result_sink
    bit hold_done;
    hold_done = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // Check every result transfer and count cycles where the core refuses input
  always @(posedge clk) begin : result_monitor
    rot_res_t got;
    if (rst_n === 1'b1) begin
      if (in_valid === 1'b1 && in_ready !== 1'b1) input_stall_cycles++;
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        got.x = out_rot_x;
        got.y = out_rot_y;
        got.z = out_rot_z;
        got.clipped = out_clipped;
        sb.check_rotation(got);
      end
    end
  end

  // Abort a hung run; the limit is many times the slowest legal run
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timeout with %0d rotations still outstanding", sb.pending());
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- quaternion_vector_rotation_core.f -----
rtl/qvr_pkg.sv
rtl/qvr_round_sat.sv
rtl/quaternion_vector_rotation_core.sv
tb/tb.sv
